/* hw/rtl/pep8_execute_unit_assert.svh */
// ----------------------------------------------------------------------------
// pep8_execute_unit_assert.svh
// Assertion macros used by the execute unit RTL.
// ----------------------------------------------------------------------------
`ifndef PEP8_EXECUTE_UNIT_ASSERT_SVH
`define PEP8_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define PEP8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pep8 execute unit: assertion failed");

// next-cycle implication
`define PEP8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pep8 execute unit: assertion failed");

`endif

/* hw/rtl/pep8_pkg.sv */
// ----------------------------------------------------------------------------
// pep8_pkg
// Types and constants of the execute unit: op codes, item layouts, flags.
// ----------------------------------------------------------------------------
`default_nettype none

package pep8_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned OpW   = 5;
  localparam int unsigned FlagW = 4;

  // flag bit positions
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_ADD     = 5'd0,
    OP_ADDSP   = 5'd1,
    OP_AND     = 5'd2,
    OP_ASL     = 5'd3,
    OP_ASR     = 5'd4,
    OP_BR      = 5'd5,
    OP_BRC     = 5'd6,
    OP_BREQ    = 5'd7,
    OP_BRGE    = 5'd8,
    OP_BRGT    = 5'd9,
    OP_BRLE    = 5'd10,
    OP_BRLT    = 5'd11,
    OP_BRNE    = 5'd12,
    OP_BRV     = 5'd13,
    OP_CALL    = 5'd14,
    OP_CP      = 5'd15,
    OP_LDBYTE  = 5'd16,
    OP_LD      = 5'd17,
    OP_MOVFLGA = 5'd18,
    OP_MOVSPA  = 5'd19,
    OP_NEG     = 5'd20,
    OP_NOT     = 5'd21,
    OP_OR      = 5'd22,
    OP_ROL     = 5'd23,
    OP_ROR     = 5'd24,
    OP_ST      = 5'd25,
    OP_STBYTE  = 5'd26,
    OP_SUB     = 5'd27,
    OP_SUBSP   = 5'd28
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             reg_sel;
    logic [WordW-1:0] operand;
    logic [WordW-1:0] eff_address;
    logic [WordW-1:0] fall_pc;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0] acc_out;
    logic [WordW-1:0] index_out;
    logic [WordW-1:0] stack_out;
    logic [WordW-1:0] pc_out;
    logic [FlagW-1:0] flags_out;
    logic             wr_enable;
    logic [WordW-1:0] wr_addr;
    logic [WordW-1:0] wr_data;
    logic             wr_byte;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/pep8_if.sv */
// ----------------------------------------------------------------------------
// pep8_if
// Valid/ready channels of the execute unit: instruction in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pep8_cmd_if;
  logic           valid;
  logic           ready;
  pep8_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pep8_res_if;
  logic           valid;
  logic           ready;
  pep8_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pep8_execute_unit.sv */
// ----------------------------------------------------------------------------
// pep8_execute_unit
// Execute stage of a 16-bit accumulator machine: one decoded instruction per
// item, updates A, X, SP and NZVC, returns the register file and a write.
// ----------------------------------------------------------------------------
//  channel  dir  payload  accepted when
//  in_i     in   cmd_t    in_i.valid  && in_i.ready
//  out_o    out  res_t    out_o.valid && out_o.ready
//
//  One item per cycle sustained while out_o is ready; an item passes the input
//  register, then ALU and flag logic into the result register.
//  Architectural registers update as an item moves into the result register.
//  Reset clears A, X, SP, flags and both valid bits.
//  A stalled output holds one result while one more item waits at the input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pep8_execute_unit_assert.svh"

module pep8_execute_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  pep8_cmd_if.sink        in_i,
  pep8_res_if.source      out_o
);

  localparam int unsigned W  = pep8_pkg::WordW;
  localparam int unsigned FW = pep8_pkg::FlagW;

  logic           s1_valid_q;
  pep8_pkg::cmd_t s1_q;
  logic           out_valid_q;
  pep8_pkg::res_t out_q;
  pep8_pkg::res_t res_d;

  logic [W-1:0]  acc_q, idx_q, sp_q;
  logic [FW-1:0] flags_q;

  logic s1_move;
  logic in_fire;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ALU
  logic [W-1:0]  r_val, r_new, add_a, add_b, neg_opnd, sp_m2;
  logic [W:0]    sum;
  logic          add_v;
  logic          wr_r, take;
  logic [FW-1:0] fl;
  logic [W-1:0]  a_new, x_new, sp_new;
  pep8_pkg::op_e op;

  always_comb begin
    op       = pep8_pkg::op_e'(s1_q.op);
    r_val    = s1_q.reg_sel ? idx_q : acc_q;
    neg_opnd = W'(~s1_q.operand) + W'(1);
    sp_m2    = sp_q - W'(2);
    add_a    = (op == pep8_pkg::OP_ADDSP || op == pep8_pkg::OP_SUBSP) ? sp_q : r_val;
    add_b    = (op == pep8_pkg::OP_SUB || op == pep8_pkg::OP_CP ||
                op == pep8_pkg::OP_SUBSP) ? neg_opnd : s1_q.operand;
    sum      = {1'b0, add_a} + {1'b0, add_b};
    add_v    = (add_a[W-1] == add_b[W-1]) && (sum[W-1] != add_a[W-1]);
  end

  always_comb begin
    r_new  = r_val;
    wr_r   = 1'b0;
    take   = 1'b0;
    fl     = flags_q;
    a_new  = acc_q;
    x_new  = idx_q;
    sp_new = sp_q;
    res_d  = '0;

    case (op)
      pep8_pkg::OP_ADD, pep8_pkg::OP_SUB: begin
        r_new = sum[W-1:0];
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_ADDSP, pep8_pkg::OP_SUBSP: sp_new = sum[W-1:0];
      pep8_pkg::OP_CP: ;
      pep8_pkg::OP_AND: begin
        r_new = r_val & s1_q.operand;
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_OR: begin
        r_new = r_val | s1_q.operand;
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_NOT: begin
        r_new = ~r_val;
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_NEG: begin
        r_new = W'(~r_val) + W'(1);
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_ASL: begin
        r_new = {r_val[W-2:0], 1'b0};
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_ASR: begin
        r_new = {r_val[W-1], r_val[W-1:1]};
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_ROL: begin
        r_new = {r_val[W-2:0], flags_q[pep8_pkg::FlagC]};
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_ROR: begin
        r_new = {flags_q[pep8_pkg::FlagC], r_val[W-1:1]};
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_LD: begin
        r_new = s1_q.operand;
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_LDBYTE: begin
        r_new = {r_val[W-1:8], s1_q.operand[7:0]};
        wr_r  = 1'b1;
      end
      pep8_pkg::OP_MOVFLGA: a_new = {{(W-FW){1'b0}}, flags_q};
      pep8_pkg::OP_MOVSPA:  a_new = sp_q;
      pep8_pkg::OP_BR:   take = 1'b1;
      pep8_pkg::OP_BRC:  take = flags_q[pep8_pkg::FlagC];
      pep8_pkg::OP_BREQ: take = flags_q[pep8_pkg::FlagZ];
      pep8_pkg::OP_BRGE: take = !flags_q[pep8_pkg::FlagN];
      pep8_pkg::OP_BRGT: take = !flags_q[pep8_pkg::FlagN] && !flags_q[pep8_pkg::FlagZ];
      pep8_pkg::OP_BRLE: take = flags_q[pep8_pkg::FlagN] || flags_q[pep8_pkg::FlagZ];
      pep8_pkg::OP_BRLT: take = flags_q[pep8_pkg::FlagN];
      pep8_pkg::OP_BRNE: take = !flags_q[pep8_pkg::FlagZ];
      pep8_pkg::OP_BRV:  take = flags_q[pep8_pkg::FlagV];
      pep8_pkg::OP_CALL: begin
        sp_new          = sp_m2;
        take            = 1'b1;
        res_d.wr_enable = 1'b1;
        res_d.wr_addr   = sp_m2;
        res_d.wr_data   = s1_q.fall_pc;
      end
      pep8_pkg::OP_ST: begin
        res_d.wr_enable = 1'b1;
        res_d.wr_addr   = s1_q.eff_address;
        res_d.wr_data   = r_val;
      end
      pep8_pkg::OP_STBYTE: begin
        res_d.wr_enable = 1'b1;
        res_d.wr_addr   = s1_q.eff_address;
        res_d.wr_data   = {8'h00, r_val[7:0]};
        res_d.wr_byte   = 1'b1;
      end
      default: ;
    endcase

    // flag updates
    case (op)
      pep8_pkg::OP_ADD, pep8_pkg::OP_SUB, pep8_pkg::OP_CP,
      pep8_pkg::OP_ADDSP, pep8_pkg::OP_SUBSP: begin
        fl[pep8_pkg::FlagN] = sum[W-1];
        fl[pep8_pkg::FlagZ] = (sum[W-1:0] == '0);
        fl[pep8_pkg::FlagV] = add_v;
        fl[pep8_pkg::FlagC] = sum[W];
      end
      pep8_pkg::OP_AND, pep8_pkg::OP_OR, pep8_pkg::OP_NOT,
      pep8_pkg::OP_LD, pep8_pkg::OP_LDBYTE: begin
        fl[pep8_pkg::FlagN] = r_new[W-1];
        fl[pep8_pkg::FlagZ] = (r_new == '0);
      end
      pep8_pkg::OP_NEG: begin
        fl[pep8_pkg::FlagN] = r_new[W-1];
        fl[pep8_pkg::FlagZ] = (r_new == '0);
        fl[pep8_pkg::FlagV] = (r_val == {1'b1, {(W-1){1'b0}}});
      end
      pep8_pkg::OP_ASL: begin
        fl[pep8_pkg::FlagN] = r_new[W-1];
        fl[pep8_pkg::FlagZ] = (r_new == '0);
        fl[pep8_pkg::FlagV] = r_val[W-1] ^ r_val[W-2];
        fl[pep8_pkg::FlagC] = r_val[W-1];
      end
      pep8_pkg::OP_ASR: begin
        fl[pep8_pkg::FlagN] = r_new[W-1];
        fl[pep8_pkg::FlagZ] = (r_new == '0);
        fl[pep8_pkg::FlagC] = r_val[0];
      end
      pep8_pkg::OP_ROL: fl[pep8_pkg::FlagC] = r_val[W-1];
      pep8_pkg::OP_ROR: fl[pep8_pkg::FlagC] = r_val[0];
      default: ;
    endcase

    if (wr_r) begin
      if (s1_q.reg_sel) begin
        x_new = r_new;
      end else begin
        a_new = r_new;
      end
    end

    res_d.acc_out   = a_new;
    res_d.index_out = x_new;
    res_d.stack_out = sp_new;
    res_d.pc_out    = take ? s1_q.operand : s1_q.fall_pc;
    res_d.flags_out = fl;
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      sp_q        <= '0;
      flags_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        acc_q       <= a_new;
        idx_q       <= x_new;
        sp_q        <= sp_new;
        flags_q     <= fl;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
    if (s1_move) begin
      out_q <= res_d;
    end
  end

  `PEP8_ASSERT_IMP(a_no_write_zero, out_valid_q && !out_q.wr_enable,
    out_q.wr_addr == '0 && out_q.wr_data == '0 && !out_q.wr_byte)
  `PEP8_ASSERT_IMP(a_byte_write, out_valid_q && out_q.wr_byte,
    out_q.wr_enable && out_q.wr_data[W-1:8] == '0)
  `PEP8_ASSERT_IMP(a_arch_matches_out, out_valid_q,
    out_q.acc_out == acc_q && out_q.index_out == idx_q &&
    out_q.stack_out == sp_q && out_q.flags_out == flags_q)
  `PEP8_ASSERT_NXT(a_move_fills_out, s1_move, out_valid_q)

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pep8_execute_unit: drives decoded instructions on
// the command channel, predicts A, X, SP, PC, NZVC and the memory write of
// each item, and compares every result field with the prediction in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpW   = pep8_pkg::OpW;
  localparam int unsigned WordW = pep8_pkg::WordW;
  localparam int unsigned FlagW = pep8_pkg::FlagW;
  localparam int unsigned FlagN = pep8_pkg::FlagN;
  localparam int unsigned FlagZ = pep8_pkg::FlagZ;
  localparam int unsigned FlagV = pep8_pkg::FlagV;
  localparam int unsigned FlagC = pep8_pkg::FlagC;

  typedef pep8_pkg::cmd_t cmd_t;
  typedef pep8_pkg::res_t res_t;

  localparam logic [OpW-1:0] OpNopFirst = 5'd29;
  localparam logic [OpW-1:0] OpNopLast  = 5'd31;

  logic clk_i;
  logic rst_ni;

  pep8_cmd_if cmd_ch ();
  pep8_res_if res_ch ();

  pep8_execute_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // predicted architectural state
  logic [WordW-1:0] acc_q, idx_q, sp_q, pc_q;
  logic [FlagW-1:0] nzvc_q;

  res_t expected_regs[$];
  int   err_cnt;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   rx_run;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("pep8_execute_unit verification failed");
    $finish;
  end

  function automatic logic [FlagW-1:0] nz_of(logic [WordW-1:0] v, logic [FlagW-1:0] f);
    logic [FlagW-1:0] g;
    g        = f;
    g[FlagN] = v[WordW-1];
    g[FlagZ] = (v == '0);
    return g;
  endfunction

  function automatic logic [WordW-1:0] add_nzvc(logic [WordW-1:0] a, logic [WordW-1:0] b,
                                                inout logic [FlagW-1:0] f);
    logic [WordW:0]   sum;
    logic [WordW-1:0] s;
    sum      = {1'b0, a} + {1'b0, b};
    s        = sum[WordW-1:0];
    f        = nz_of(s, f);
    f[FlagV] = (a[WordW-1] == b[WordW-1]) && (s[WordW-1] != a[WordW-1]);
    f[FlagC] = sum[WordW];
    return s;
  endfunction

  function automatic logic [WordW-1:0] twos(logic [WordW-1:0] v);
    return ~v + 16'd1;
  endfunction

  // executes one instruction against the predicted state
  function automatic res_t exec_instr(cmd_t c);
    res_t             r;
    logic [WordW-1:0] rv, old;
    logic [FlagW-1:0] f;
    logic             upd, take;
    r    = '0;
    upd  = 1'b0;
    take = 1'b0;
    rv   = c.reg_sel ? idx_q : acc_q;
    f    = nzvc_q;
    pc_q = c.fall_pc;
    case (c.op)
      pep8_pkg::OP_ADD: begin
        rv  = add_nzvc(rv, c.operand, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_ADDSP:  sp_q = add_nzvc(sp_q, c.operand, f);
      pep8_pkg::OP_AND: begin
        rv  = rv & c.operand;
        f   = nz_of(rv, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_ASL: begin
        old      = rv;
        rv       = {old[WordW-2:0], 1'b0};
        f[FlagC] = old[WordW-1];
        f[FlagV] = old[WordW-1] ^ rv[WordW-1];
        f        = nz_of(rv, f);
        upd      = 1'b1;
      end
      pep8_pkg::OP_ASR: begin
        old      = rv;
        rv       = {old[WordW-1], old[WordW-1:1]};
        f[FlagC] = old[0];
        f        = nz_of(rv, f);
        upd      = 1'b1;
      end
      pep8_pkg::OP_BR:   take = 1'b1;
      pep8_pkg::OP_BRC:  take = nzvc_q[FlagC];
      pep8_pkg::OP_BREQ: take = nzvc_q[FlagZ];
      pep8_pkg::OP_BRGE: take = !nzvc_q[FlagN];
      pep8_pkg::OP_BRGT: take = !nzvc_q[FlagN] && !nzvc_q[FlagZ];
      pep8_pkg::OP_BRLE: take = nzvc_q[FlagZ] || nzvc_q[FlagN];
      pep8_pkg::OP_BRLT: take = nzvc_q[FlagN];
      pep8_pkg::OP_BRNE: take = !nzvc_q[FlagZ];
      pep8_pkg::OP_BRV:  take = nzvc_q[FlagV];
      pep8_pkg::OP_CALL: begin
        sp_q        = sp_q - 16'd2;
        r.wr_enable = 1'b1;
        r.wr_addr   = sp_q;
        r.wr_data   = c.fall_pc;
        take        = 1'b1;
      end
      pep8_pkg::OP_CP:     void'(add_nzvc(rv, twos(c.operand), f));
      pep8_pkg::OP_LDBYTE: begin
        rv  = {rv[WordW-1:8], c.operand[7:0]};
        f   = nz_of(rv, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_LD: begin
        rv  = c.operand;
        f   = nz_of(rv, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_MOVFLGA: acc_q = {{(WordW-FlagW){1'b0}}, nzvc_q};
      pep8_pkg::OP_MOVSPA:  acc_q = sp_q;
      pep8_pkg::OP_NEG: begin
        f[FlagV] = (rv == 16'h8000);
        rv       = twos(rv);
        f        = nz_of(rv, f);
        upd      = 1'b1;
      end
      pep8_pkg::OP_NOT: begin
        rv  = ~rv;
        f   = nz_of(rv, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_OR: begin
        rv  = rv | c.operand;
        f   = nz_of(rv, f);
        upd = 1'b1;
      end
      pep8_pkg::OP_ROL: begin
        old      = rv;
        rv       = {old[WordW-2:0], nzvc_q[FlagC]};
        f[FlagC] = old[WordW-1];
        upd      = 1'b1;
      end
      pep8_pkg::OP_ROR: begin
        old      = rv;
        rv       = {nzvc_q[FlagC], old[WordW-1:1]};
        f[FlagC] = old[0];
        upd      = 1'b1;
      end
      pep8_pkg::OP_ST: begin
        r.wr_enable = 1'b1;
        r.wr_addr   = c.eff_address;
        r.wr_data   = rv;
      end
      pep8_pkg::OP_STBYTE: begin
        r.wr_enable = 1'b1;
        r.wr_addr   = c.eff_address;
        r.wr_data   = {8'h00, rv[7:0]};
        r.wr_byte   = 1'b1;
      end
      pep8_pkg::OP_SUB: begin
        rv  = add_nzvc(rv, twos(c.operand), f);
        upd = 1'b1;
      end
      pep8_pkg::OP_SUBSP: sp_q = add_nzvc(sp_q, twos(c.operand), f);
      default: ;
    endcase
    if (upd) begin
      if (c.reg_sel) idx_q = rv;
      else acc_q = rv;
    end
    nzvc_q = f;
    if (take) pc_q = c.operand;
    r.acc_out   = acc_q;
    r.index_out = idx_q;
    r.stack_out = sp_q;
    r.pc_out    = pc_q;
    r.flags_out = nzvc_q;
    return r;
  endfunction

  function automatic int pick_len(int pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'h0001;
      5:       return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_t mk_cmd(logic [OpW-1:0] op, logic sel, logic [WordW-1:0] opnd,
                                  logic [WordW-1:0] ea = 16'h0000,
                                  logic [WordW-1:0] fall = 16'h0104);
    cmd_t c;
    c.op          = op;
    c.reg_sel     = sel;
    c.operand     = opnd;
    c.eff_address = ea;
    c.fall_pc     = fall;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    return mk_cmd(OpW'($urandom_range(0, 31)), 1'($urandom), pick_word(), pick_word(),
                  pick_word());
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = pick_len(tx_idle_pct);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    expected_regs.push_back(exec_instr(c));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (expected_regs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cmp_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_run > 0) begin
      rx_run--;
    end else begin
      rx_run = pick_len(rx_stall_pct);
      if (rx_run > 0) begin
        res_ch.ready <= 1'b0;
        rx_run--;
      end else begin
        res_ch.ready <= 1'b1;
        rx_run = $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_regs.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none pending, actual %h", $time, got);
      end else begin
        want = expected_regs.pop_front();
        cmp_field("acc_out", want.acc_out, got.acc_out);
        cmp_field("index_out", want.index_out, got.index_out);
        cmp_field("stack_out", want.stack_out, got.stack_out);
        cmp_field("pc_out", want.pc_out, got.pc_out);
        cmp_field("flags_out", 16'(want.flags_out), 16'(got.flags_out));
        cmp_field("wr_enable", 16'(want.wr_enable), 16'(got.wr_enable));
        cmp_field("wr_addr", want.wr_addr, got.wr_addr);
        cmp_field("wr_data", want.wr_data, got.wr_data);
        cmp_field("wr_byte", 16'(want.wr_byte), 16'(got.wr_byte));
      end
    end
  end

  task automatic test_arith_directed();
    send_cmd(mk_cmd(pep8_pkg::OP_LD, 1'b0, 16'h7FFF));
    send_cmd(mk_cmd(pep8_pkg::OP_ADD, 1'b0, 16'h0001));     // signed overflow
    send_cmd(mk_cmd(pep8_pkg::OP_ADD, 1'b0, 16'h8000));     // carry, overflow, zero
    send_cmd(mk_cmd(pep8_pkg::OP_LD, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(pep8_pkg::OP_SUB, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(pep8_pkg::OP_CP, 1'b0, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_LD, 1'b0, 16'h8000));
    send_cmd(mk_cmd(pep8_pkg::OP_NEG, 1'b0, 16'h0000));     // most negative value
    send_cmd(mk_cmd(pep8_pkg::OP_ASL, 1'b0, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_ROL, 1'b0, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_ROR, 1'b0, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_LDBYTE, 1'b1, 16'hABCD));
    send_cmd(mk_cmd(pep8_pkg::OP_ASR, 1'b1, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_AND, 1'b1, 16'hF0F0));
    send_cmd(mk_cmd(pep8_pkg::OP_OR, 1'b1, 16'h000F));
    send_cmd(mk_cmd(pep8_pkg::OP_NOT, 1'b1, 16'h0000));
    send_cmd(mk_cmd(pep8_pkg::OP_MOVFLGA, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(pep8_pkg::OP_SUBSP, 1'b0, 16'h8000));
    send_cmd(mk_cmd(pep8_pkg::OP_ADDSP, 1'b1, 16'hFFFE));
    send_cmd(mk_cmd(pep8_pkg::OP_MOVSPA, 1'b1, 16'h0000));
  endtask

  task automatic test_flow_directed();
    send_cmd(mk_cmd(pep8_pkg::OP_CALL, 1'b1, 16'h1234, 16'h0000, 16'hBEEF));
    send_cmd(mk_cmd(pep8_pkg::OP_ST, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_cmd(mk_cmd(pep8_pkg::OP_STBYTE, 1'b0, 16'h0000, 16'h8001, 16'h0000));
    for (int k = pep8_pkg::OP_BR; k <= pep8_pkg::OP_BRV; k++) begin
      send_cmd(mk_cmd(OpW'(k), 1'b0, 16'hC0DE + 16'(k), 16'h0000, 16'h0200));
    end
    send_cmd(mk_cmd(OpNopFirst, 1'b0, 16'h1111, 16'h2222, 16'h3333));
    send_cmd(mk_cmd(OpNopLast, 1'b1, 16'hFFFF, 16'hFFFF, 16'h5555));
  endtask

  task automatic test_random_mix(int n);
    for (int k = 0; k < n; k++) begin
      send_cmd(rand_cmd());
      if (k % 150 == 149) drain_results();
    end
  endtask

  task automatic test_full_rate(int n);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int k = 0; k < n; k++) send_cmd(rand_cmd());
  endtask

  task automatic test_heavy_stall(int n);
    tx_idle_pct  = 40;
    rx_stall_pct = 60;
    for (int k = 0; k < n; k++) send_cmd(rand_cmd());
  endtask

  initial begin
    rst_ni        = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    res_ch.ready  = 1'b0;
    acc_q         = '0;
    idx_q         = '0;
    sp_q          = '0;
    pc_q          = '0;
    nzvc_q        = '0;
    err_cnt       = 0;
    rx_run        = 0;
    tx_idle_pct   = 20;
    rx_stall_pct  = 20;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_arith_directed();
    test_flow_directed();
    drain_results();
    test_random_mix(900);
    test_full_rate(250);
    test_heavy_stall(200);
    drain_results();
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("pep8_execute_unit verification clean");
    end else begin
      $display("pep8_execute_unit verification failed");
    end
    $finish;
  end

endmodule
